// ===== rtl/core/hrsc_pkg.sv =====
// shared types, constants and character tables for the response stream checker
package hrsc_pkg;

    // fixed field widths
    localparam int POS_W    = 17;
    localparam int BODY_W   = 17;
    localparam int CAP_W    = 17;
    localparam int STATUS_W = 16;
    localparam int CODE_W   = 10;

    // verdict codes
    localparam logic [1:0] VERDICT_OK    = 2'd0;
    localparam logic [1:0] VERDICT_PARSE = 2'd1;
    localparam logic [1:0] VERDICT_TRUNC = 2'd2;

    // content-length value phases
    localparam logic [1:0] PHASE_IDLE  = 2'd0;
    localparam logic [1:0] PHASE_VALUE = 2'd1;
    localparam logic [1:0] PHASE_DONE  = 2'd2;

    // framing of the status line
    localparam int PREFIX_LEN   = 7;
    localparam int KEY_LEN      = 15;
    localparam int STATUS_FIRST = 9;
    localparam int STATUS_LAST  = 11;
    localparam int MIN_LEN      = 12;
    localparam int STATUS_MIN   = 100;
    localparam int STATUS_MAX   = 599;
    localparam int CAP_FLOOR    = 64;
    localparam int SEP_LEN      = 4;

    // characters
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LOW_C = 8'h63;
    localparam logic [7:0] CASE_GAP   = 8'h20;

    // one input request
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       is_last;
    } in_item_t;

    // control from the stream logic to the header scanner
    typedef struct packed {
        logic hdr_take;
        logic clear;
    } hdr_ctrl_t;

    // status from the header scanner
    typedef struct packed {
        logic header_ended;
        logic header_ended_next;
        logic truncated;
    } hdr_stat_t;

    // expected bytes of the "HTTP/1." prefix
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h48;
            3'd1:    c = 8'h54;
            3'd2:    c = 8'h54;
            3'd3:    c = 8'h50;
            3'd4:    c = 8'h2F;
            3'd5:    c = 8'h31;
            3'd6:    c = 8'h2E;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // expected bytes of the lower-case "content-length:" key
    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h63;
            4'd1:    c = 8'h6F;
            4'd2:    c = 8'h6E;
            4'd3:    c = 8'h74;
            4'd4:    c = 8'h65;
            4'd5:    c = 8'h6E;
            4'd6:    c = 8'h74;
            4'd7:    c = 8'h2D;
            4'd8:    c = 8'h6C;
            4'd9:    c = 8'h65;
            4'd10:   c = 8'h6E;
            4'd11:   c = 8'h67;
            4'd12:   c = 8'h74;
            4'd13:   c = 8'h68;
            4'd14:   c = 8'h3A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/hrsc_in_stage.sv =====
// input register stage with valid/stall handshake
module hrsc_in_stage import hrsc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_item,
    input  logic     advance,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     load;

    // hold the request while the result side cannot take it
    assign in_stall   = valid_reg && !advance;
    assign load       = in_valid && !in_stall;
    assign valid_next = load || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/core/hrsc_hdr_scan.sv =====
// header scanner: separator search, content-length key match and value parse
module hrsc_hdr_scan import hrsc_pkg::*;
#(
    parameter int MAX_BYTES = 65536
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  hdr_ctrl_t         ctrl,
    input  logic [7:0]        data_byte,
    input  logic [BODY_W-1:0] body_count_next,
    output hdr_stat_t         stat
);

    localparam int LEN_W = $clog2(MAX_BYTES + 2);
    localparam int PW    = LEN_W + 4;
    localparam int CMP_W = (LEN_W > BODY_W) ? LEN_W : BODY_W;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_BYTES);
    localparam logic [LEN_W-1:0] LEN_SAT = LEN_W'(MAX_BYTES + 1);
    localparam logic [PW-1:0]    SAT_WIDE = PW'(MAX_BYTES + 1);

    logic [2:0]       sep_reg, sep_next, sep_upd;
    logic             ended_reg, ended_next, ended_upd;
    logic [3:0]       key_reg, key_next, key_upd;
    logic [1:0]       phase_reg, phase_next, phase_upd;
    logic [LEN_W-1:0] len_reg, len_next, len_upd;
    logic             digit_reg, digit_next, digit_upd;

    logic [7:0]       low_byte;
    logic [7:0]       sep_expect;
    logic             is_blank;
    logic             is_digit;
    logic [PW-1:0]    len_prod;

    assign low_byte = (data_byte >= CHAR_UP_A && data_byte <= CHAR_UP_Z)
                      ? data_byte + CASE_GAP : data_byte;
    assign is_blank = (data_byte == CHAR_SPACE) || (data_byte == CHAR_TAB);
    assign is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
    assign len_prod = PW'({len_reg, 3'b000}) + PW'({len_reg, 1'b0})
                    + PW'(data_byte[3:0]);

    // key match and value accumulation
    always_comb
    begin
        key_upd   = key_reg;
        phase_upd = phase_reg;
        len_upd   = len_reg;
        digit_upd = digit_reg;
        unique case (phase_reg)
            PHASE_IDLE:
            begin
                if (key_reg < 4'(KEY_LEN) && low_byte == key_char(key_reg))
                begin
                    key_upd = key_reg + 4'd1;
                    if (key_reg == 4'(KEY_LEN - 1))
                    begin
                        phase_upd = PHASE_VALUE;
                    end
                end
                else
                begin
                    key_upd = (low_byte == CHAR_LOW_C) ? 4'd1 : 4'd0;
                end
            end
            PHASE_VALUE:
            begin
                if (is_blank)
                begin
                    if (digit_reg)
                    begin
                        phase_upd = PHASE_DONE;
                    end
                end
                else if (is_digit)
                begin
                    if (len_reg > LEN_MAX || len_prod > SAT_WIDE)
                    begin
                        len_upd = LEN_SAT;
                    end
                    else
                    begin
                        len_upd = len_prod[LEN_W-1:0];
                    end
                    digit_upd = 1'b1;
                end
                else
                begin
                    phase_upd = PHASE_DONE;
                end
            end
            default:
            begin
                phase_upd = phase_reg;
            end
        endcase
    end

    // blank-line separator search
    assign sep_expect = sep_reg[0] ? CHAR_LF : CHAR_CR;

    always_comb
    begin
        ended_upd = ended_reg;
        if (data_byte == sep_expect)
        begin
            sep_upd = sep_reg + 3'd1;
            if (sep_reg == 3'(SEP_LEN - 1))
            begin
                ended_upd = 1'b1;
            end
        end
        else
        begin
            sep_upd = (data_byte == CHAR_CR) ? 3'd1 : 3'd0;
        end
    end

    // next state: clear at end of response, else apply header byte
    always_comb
    begin
        if (ctrl.clear)
        begin
            sep_next   = 3'd0;
            ended_next = 1'b0;
            key_next   = 4'd0;
            phase_next = PHASE_IDLE;
            len_next   = '0;
            digit_next = 1'b0;
        end
        else if (ctrl.hdr_take)
        begin
            sep_next   = sep_upd;
            ended_next = ended_upd;
            key_next   = key_upd;
            phase_next = phase_upd;
            len_next   = len_upd;
            digit_next = digit_upd;
        end
        else
        begin
            sep_next   = sep_reg;
            ended_next = ended_reg;
            key_next   = key_reg;
            phase_next = phase_reg;
            len_next   = len_reg;
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg   <= 3'd0;
            ended_reg <= 1'b0;
            key_reg   <= 4'd0;
            phase_reg <= PHASE_IDLE;
            len_reg   <= '0;
            digit_reg <= 1'b0;
        end
        else
        begin
            sep_reg   <= sep_next;
            ended_reg <= ended_next;
            key_reg   <= key_next;
            phase_reg <= phase_next;
            len_reg   <= len_next;
            digit_reg <= digit_next;
        end
    end

    // status as seen after this request's byte
    always_comb
    begin
        stat.header_ended = ended_reg;
        if (ctrl.hdr_take)
        begin
            stat.header_ended_next = ended_upd;
            stat.truncated = digit_upd
                             && (CMP_W'(len_upd) != CMP_W'(body_count_next));
        end
        else
        begin
            stat.header_ended_next = ended_reg;
            stat.truncated = digit_reg
                             && (CMP_W'(len_reg) != CMP_W'(body_count_next));
        end
    end

endmodule

// ===== rtl/core/http_response_stream_checker_unit.sv =====
// a request passes through the input register and then the result register
// throughput: one request per cycle while results are taken; under a stalled result
// one more request waits in the input register, then the input side stalls
// the result register frees the input side as soon as the result is taken
// reset clears all parsing state and sets capacity to 65536 (clamped)
// each request gives exactly one result; a last request returns parsing state to reset
module http_response_stream_checker_unit import hrsc_pkg::*;
#(
    parameter int MAX_BYTES = 65536
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic [CAP_W-1:0]  cfg_write_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              byte_present,
    input  logic              is_last,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              body_valid,
    output logic [7:0]        body_byte,
    output logic              done_res,
    output logic [1:0]        verdict,
    output logic [CODE_W-1:0] status_code,
    output logic [BODY_W-1:0] body_length
);

    localparam int CAP_RESET_INT = (MAX_BYTES < 65536) ? MAX_BYTES : 65536;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(CAP_RESET_INT);
    localparam logic [31:0]      MAX_WIDE  = 32'(MAX_BYTES);

    in_item_t   in_item;
    in_item_t   item;
    logic       item_valid;
    logic       out_free;
    logic       step;

    logic [CAP_W-1:0]           cap_reg, cap_next;
    logic [POS_W-1:0]           pos_reg, pos_next, pos_upd;
    logic                       prefix_reg, prefix_next, prefix_upd;
    logic signed [STATUS_W-1:0] status_reg, status_next, status_upd;
    logic [BODY_W-1:0]          body_reg, body_next, body_upd;

    logic       take;
    logic       body_take;
    logic       parse_err;
    logic [1:0] verdict_calc;
    logic signed [STATUS_W-1:0] status_digit;

    hdr_ctrl_t  hdr_ctrl;
    hdr_stat_t  hdr_stat;

    logic              out_valid_reg;
    logic              body_valid_reg;
    logic [7:0]        body_byte_reg;
    logic              done_reg;
    logic [1:0]        verdict_reg;
    logic [CODE_W-1:0] status_code_reg;
    logic [BODY_W-1:0] body_length_reg;

    // input register
    assign in_item.data_byte    = data_byte;
    assign in_item.byte_present = byte_present;
    assign in_item.is_last      = is_last;

    assign out_free = !out_valid_reg || !out_stall;
    assign step     = item_valid && out_free;

    hrsc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .advance    (out_free),
        .item_valid (item_valid),
        .item       (item)
    );

    // capacity register, stored already clamped
    always_comb
    begin
        if (cfg_write_data < CAP_W'(CAP_FLOOR))
        begin
            cap_next = CAP_W'(CAP_FLOOR);
        end
        else if (32'(cfg_write_data) > MAX_WIDE)
        begin
            cap_next = CAP_W'(MAX_BYTES);
        end
        else
        begin
            cap_next = cfg_write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_write_en)
        begin
            cap_reg <= cap_next;
        end
    end

    // byte acceptance and routing
    assign take      = item.byte_present && (pos_reg < cap_reg);
    assign body_take = take && hdr_stat.header_ended;

    assign hdr_ctrl.hdr_take = step && take && !hdr_stat.header_ended;
    assign hdr_ctrl.clear    = step && item.is_last;

    hrsc_hdr_scan #(
        .MAX_BYTES (MAX_BYTES)
    ) u_hdr_scan (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (hdr_ctrl),
        .data_byte       (item.data_byte),
        .body_count_next (body_upd),
        .stat            (hdr_stat)
    );

    // prefix check, status digits, position and body count
    assign status_digit = $signed({8'b0, item.data_byte}) - STATUS_W'(48);

    always_comb
    begin
        prefix_upd = prefix_reg;
        status_upd = status_reg;
        if (take && pos_reg < POS_W'(PREFIX_LEN)
            && item.data_byte != prefix_char(pos_reg[2:0]))
        begin
            prefix_upd = 1'b0;
        end
        if (take && pos_reg >= POS_W'(STATUS_FIRST) && pos_reg <= POS_W'(STATUS_LAST))
        begin
            status_upd = (status_reg <<< 3) + (status_reg <<< 1) + status_digit;
        end
        pos_upd  = take ? pos_reg + POS_W'(1) : pos_reg;
        body_upd = body_take ? body_reg + BODY_W'(1) : body_reg;
    end

    // verdict for the end of a response
    assign parse_err = (pos_upd < POS_W'(MIN_LEN)) || !prefix_upd
                       || (status_upd < STATUS_W'(STATUS_MIN))
                       || (status_upd > STATUS_W'(STATUS_MAX))
                       || !hdr_stat.header_ended_next;

    always_comb
    begin
        if (parse_err)
        begin
            verdict_calc = VERDICT_PARSE;
        end
        else if (hdr_stat.truncated)
        begin
            verdict_calc = VERDICT_TRUNC;
        end
        else
        begin
            verdict_calc = VERDICT_OK;
        end
    end

    // stream state update
    always_comb
    begin
        if (item.is_last)
        begin
            pos_next    = '0;
            prefix_next = 1'b1;
            status_next = '0;
            body_next   = '0;
        end
        else
        begin
            pos_next    = pos_upd;
            prefix_next = prefix_upd;
            status_next = status_upd;
            body_next   = body_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            prefix_reg <= 1'b1;
            status_reg <= '0;
            body_reg   <= '0;
        end
        else if (step)
        begin
            pos_reg    <= pos_next;
            prefix_reg <= prefix_next;
            status_reg <= status_next;
            body_reg   <= body_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            body_valid_reg  <= body_take;
            body_byte_reg   <= body_take ? item.data_byte : 8'd0;
            done_reg        <= item.is_last;
            verdict_reg     <= item.is_last ? verdict_calc : VERDICT_OK;
            status_code_reg <= (item.is_last && verdict_calc == VERDICT_OK)
                               ? status_upd[CODE_W-1:0] : '0;
            body_length_reg <= (item.is_last && verdict_calc == VERDICT_OK)
                               ? body_upd : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign body_valid  = body_valid_reg;
    assign body_byte   = body_byte_reg;
    assign done_res    = done_reg;
    assign verdict     = verdict_reg;
    assign status_code = status_code_reg;
    assign body_length = body_length_reg;

endmodule

// ===== rtl/core/hrsc_checker.sv =====
// port-level checks for the response stream checker, bound to the top level
module hrsc_checker import hrsc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              cfg_write_en,
    input logic [CAP_W-1:0]  cfg_write_data,
    input logic              in_valid,
    input logic              in_stall,
    input logic [7:0]        data_byte,
    input logic              byte_present,
    input logic              is_last,
    input logic              out_valid,
    input logic              out_stall,
    input logic              body_valid,
    input logic [7:0]        body_byte,
    input logic              done_res,
    input logic [1:0]        verdict,
    input logic [CODE_W-1:0] status_code,
    input logic [BODY_W-1:0] body_length
);

    // verdict fields are zero on requests that do not end a response
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !done_res |-> verdict == VERDICT_OK && status_code == '0
                                   && body_length == '0)
        else $error("verdict fields set without end of response");

    // a failed response reports neither status nor length
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res && verdict != VERDICT_OK
        |-> status_code == '0 && body_length == '0
            && (verdict == VERDICT_PARSE || verdict == VERDICT_TRUNC))
        else $error("failed verdict carries status or length");

    // a good response has a status in the accepted range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res && verdict == VERDICT_OK
        |-> status_code >= CODE_W'(STATUS_MIN) && status_code <= CODE_W'(STATUS_MAX))
        else $error("good verdict with status out of range");

    // no body byte without the body flag
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !body_valid |-> body_byte == 8'd0)
        else $error("body byte set without body flag");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(body_valid)
                                   && $stable(body_byte) && $stable(done_res)
                                   && $stable(verdict) && $stable(body_length))
        else $error("stalled result changed");

endmodule

bind http_response_stream_checker_unit hrsc_checker u_hrsc_checker (.*);
